/* design/sntp_pkg.sv */
package sntp_pkg;

    // sync phases, as seen on the result phase field
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_LOOKUP = 2'd1,
        PH_AWAIT  = 2'd2,
        PH_SYNCED = 2'd3
    } phase_t;

    // event kinds carried on the input tuser
    typedef enum logic [1:0] {
        EV_TICK   = 2'd0,
        EV_START  = 2'd1,
        EV_LOOKUP = 2'd2,
        EV_REPLY  = 2'd3
    } event_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_RETRY   = 2'd0,
        REG_RESYNC  = 2'd1,
        REG_TIMEOUT = 2'd2,
        REG_TZ      = 2'd3
    } cfg_reg_t;

    // control fields that travel with each result down the pipeline
    typedef struct packed {
        phase_t phase;
        logic   synced;
        logic   lookup_req;
        logic   send_req;
    } ctl_t;

    // seconds between 1900 and 1970
    localparam logic [31:0] EPOCH_1970 = 32'd2208988800;

    // register reset values
    localparam logic [31:0] RETRY_MS_RST   = 32'd30000;
    localparam logic [31:0] RESYNC_MS_RST  = 32'd3600000;
    localparam logic [31:0] TIMEOUT_MS_RST = 32'd5000;
    localparam logic [4:0]  TZ_HOURS_RST   = 5'd0;

    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

    // reciprocals for exact constant division of 32-bit values
    // x / 1000 = (x * RECIP_1000) >> 38
    localparam logic [28:0] RECIP_1000 = 29'd274877907;
    // x / 60 = (x * RECIP_60) >> 37
    localparam logic [31:0] RECIP_60   = 32'd2290649225;
    // x / 3 = (x * RECIP_3) >> 20, for x below 2^18
    localparam logic [18:0] RECIP_3    = 19'd349526;

endpackage

/* design/sntp_sync_timekeeper.sv */
// SNTP client sequencer and time-of-day clock.
// Input channel s_*: one event per transfer. tuser holds the event kind
// (tick, start, lookup result, reply); tdata holds elapsed ms, lookup ok,
// reply long enough and the reply transmit seconds since 1900.
// Output channel m_*: exactly one result per input event, in order, with
// the phase after the event, the synced flag, the lookup and send request
// strobes and the local time of day (zero until the first valid sync).
// Config channel cfg_*: writes retry, resync, reply timeout and zone offset;
// always ready, write only while no event is in flight.
// Throughput: one event per cycle while s_tready is high. Phase state is
// updated in the cycle the event is taken; the time of day then runs through
// a 10-stage pipeline of reciprocal multiplies (ms to s, s to minutes,
// minutes to hours, mod 24), and a result is presented from the last stage
// register and transfers when the output is free.
// Each stage holds while it is full and the next one cannot move, so a stalled
// receiver only backs up the input once all 10 stages are occupied.
// Reset: phase idle, counters and sync base cleared, registers at defaults,
// pipeline empty.
module sntp_sync_timekeeper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] elapsed_ms, [16] lookup_ok, [17] reply_long_enough,
    // [49:18] reply_seconds, [55:50] zero
    input  logic [55:0] s_tdata,
    // [1:0] func
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] phase, [2] synced_flag, [3] lookup_request, [4] send_request,
    // [9:5] hours, [15:10] minutes, [21:16] seconds, [23:22] zero
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int NUM_STAGES = 10;

    // configuration registers
    logic [31:0] retry_ms_reg;
    logic [31:0] resync_ms_reg;
    logic [31:0] timeout_ms_reg;
    logic [4:0]  tz_hours_reg;

    // sequencer state
    sntp_pkg::phase_t phase_reg, phase_next;
    logic [31:0] phase_elapsed_reg, phase_elapsed_next;
    logic [31:0] unix_base_reg, unix_base_next;
    logic [31:0] ms_since_sync_reg, ms_since_sync_next;
    logic        have_sync_reg, have_sync_next;
    logic        lookup_req, send_req;

    // input fields
    sntp_pkg::event_t func;
    logic [15:0] elapsed_ms;
    logic        lookup_ok;
    logic        reply_long_enough;
    logic [31:0] reply_seconds;
    logic        in_xfer;
    logic [31:0] pe_sum;
    logic [31:0] ms_sum;

    // pipeline handshake
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] rdy;

    // pipeline payload
    sntp_pkg::ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;
    sntp_pkg::ctl_t ctl6_reg, ctl7_reg, ctl8_reg, ctl9_reg, ctl10_reg;
    logic [31:0] base1_reg, base2_reg;
    logic [31:0] ms1_reg;
    logic [4:0]  tz1_reg, tz2_reg;
    logic [60:0] prod2_reg;
    logic [31:0] tday3_reg;
    logic [15:0] tz_amt3_reg;
    logic        tz_neg3_reg;
    logic [31:0] t4_reg;
    logic [5:0]  t_lo5_reg;
    logic [63:0] prod5_reg;
    logic [5:0]  ss6_reg, ss7_reg, ss8_reg, ss9_reg, ss10_reg;
    logic [26:0] q60_6_reg;
    logic [5:0]  q60_lo7_reg;
    logic [58:0] prod7_reg;
    logic [5:0]  mm8_reg, mm9_reg, mm10_reg;
    logic [20:0] h8_reg;
    logic [4:0]  h_lo9_reg;
    logic [36:0] prod9_reg;
    logic [4:0]  hh10_reg;

    // stage helpers
    logic [4:0]  tz_neg_hours;
    logic [15:0] tz_amt;
    logic [26:0] q60_a;
    logic [20:0] q3600;
    logic [16:0] q24;
    sntp_pkg::ctl_t ctl_in;

    assign func              = sntp_pkg::event_t'(s_tuser);
    assign elapsed_ms        = s_tdata[15:0];
    assign lookup_ok         = s_tdata[16];
    assign reply_long_enough = s_tdata[17];
    assign reply_seconds     = s_tdata[49:18];
    assign in_xfer           = s_tvalid && s_tready;
    assign cfg_ready         = 1'b1;

    // configuration writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_ms_reg   <= sntp_pkg::RETRY_MS_RST;
            resync_ms_reg  <= sntp_pkg::RESYNC_MS_RST;
            timeout_ms_reg <= sntp_pkg::TIMEOUT_MS_RST;
            tz_hours_reg   <= sntp_pkg::TZ_HOURS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (sntp_pkg::cfg_reg_t'(cfg_index))
                sntp_pkg::REG_RETRY:   retry_ms_reg   <= cfg_data;
                sntp_pkg::REG_RESYNC:  resync_ms_reg  <= cfg_data;
                sntp_pkg::REG_TIMEOUT: timeout_ms_reg <= cfg_data;
                sntp_pkg::REG_TZ:      tz_hours_reg   <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    // phase sequencer, next state for one event
    always_comb
    begin
        pe_sum             = phase_elapsed_reg + {16'd0, elapsed_ms};
        ms_sum             = ms_since_sync_reg + {16'd0, elapsed_ms};
        phase_next         = phase_reg;
        phase_elapsed_next = phase_elapsed_reg;
        unix_base_next     = unix_base_reg;
        ms_since_sync_next = ms_since_sync_reg;
        have_sync_next     = have_sync_reg;
        lookup_req         = 1'b0;
        send_req           = 1'b0;
        case (func)
            sntp_pkg::EV_TICK:
            begin
                phase_elapsed_next = pe_sum;
                if (have_sync_reg)
                begin
                    ms_since_sync_next = ms_sum;
                end
                case (phase_reg)
                    sntp_pkg::PH_IDLE:
                    begin
                        if (pe_sum >= retry_ms_reg)
                        begin
                            phase_next         = sntp_pkg::PH_LOOKUP;
                            phase_elapsed_next = '0;
                            lookup_req         = 1'b1;
                        end
                    end
                    sntp_pkg::PH_LOOKUP:
                    begin
                        if (pe_sum >= retry_ms_reg)
                        begin
                            phase_next         = sntp_pkg::PH_IDLE;
                            phase_elapsed_next = '0;
                        end
                    end
                    sntp_pkg::PH_AWAIT:
                    begin
                        if (pe_sum >= timeout_ms_reg)
                        begin
                            phase_next         = sntp_pkg::PH_IDLE;
                            phase_elapsed_next = '0;
                        end
                    end
                    default:
                    begin
                        if (pe_sum >= resync_ms_reg)
                        begin
                            phase_next         = sntp_pkg::PH_LOOKUP;
                            phase_elapsed_next = '0;
                            lookup_req         = 1'b1;
                        end
                    end
                endcase
            end
            sntp_pkg::EV_START:
            begin
                phase_next         = sntp_pkg::PH_LOOKUP;
                phase_elapsed_next = '0;
                lookup_req         = 1'b1;
            end
            sntp_pkg::EV_LOOKUP:
            begin
                phase_elapsed_next = '0;
                if (lookup_ok)
                begin
                    phase_next = sntp_pkg::PH_AWAIT;
                    send_req   = 1'b1;
                end
                else
                begin
                    phase_next = sntp_pkg::PH_IDLE;
                end
            end
            default:
            begin
                // reply: short packets are dropped, pre-1970 stamps restart
                if (reply_long_enough)
                begin
                    phase_elapsed_next = '0;
                    if (reply_seconds < sntp_pkg::EPOCH_1970)
                    begin
                        phase_next = sntp_pkg::PH_LOOKUP;
                    end
                    else
                    begin
                        phase_next         = sntp_pkg::PH_SYNCED;
                        unix_base_next     = reply_seconds - sntp_pkg::EPOCH_1970;
                        ms_since_sync_next = '0;
                        have_sync_next     = 1'b1;
                    end
                end
            end
        endcase
    end

    // sequencer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= sntp_pkg::PH_IDLE;
            phase_elapsed_reg <= '0;
            unix_base_reg     <= '0;
            ms_since_sync_reg <= '0;
            have_sync_reg     <= 1'b0;
        end
        else if (in_xfer)
        begin
            phase_reg         <= phase_next;
            phase_elapsed_reg <= phase_elapsed_next;
            unix_base_reg     <= unix_base_next;
            ms_since_sync_reg <= ms_since_sync_next;
            have_sync_reg     <= have_sync_next;
        end
    end

    // per-stage ready: a stage moves when empty or when the next one moves
    always_comb
    begin
        rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_tready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage helpers
    always_comb
    begin
        ctl_in.phase      = phase_next;
        ctl_in.synced     = have_sync_next;
        ctl_in.lookup_req = lookup_req;
        ctl_in.send_req   = send_req;
        // negative offset code means 32 - code hours
        tz_neg_hours      = 5'd0 - tz2_reg;
        if (tz2_reg[4])
        begin
            tz_amt = 16'(tz_neg_hours * sntp_pkg::SECS_PER_HOUR);
        end
        else
        begin
            tz_amt = 16'(tz2_reg[3:0] * sntp_pkg::SECS_PER_HOUR);
        end
        q60_a = prod5_reg[63:37];
        q3600 = prod7_reg[57:37];
        q24   = prod9_reg[36:20];
    end

    // time-of-day pipeline payload
    always_ff @(posedge clk)
    begin
        // snapshot of the state after the event
        if (rdy[0])
        begin
            ctl1_reg  <= ctl_in;
            base1_reg <= unix_base_next;
            ms1_reg   <= ms_since_sync_next;
            tz1_reg   <= tz_hours_reg;
        end
        // ms to seconds, multiply
        if (rdy[1])
        begin
            ctl2_reg  <= ctl1_reg;
            base2_reg <= base1_reg;
            tz2_reg   <= tz1_reg;
            prod2_reg <= ms1_reg * sntp_pkg::RECIP_1000;
        end
        // base plus whole seconds, zone amount
        if (rdy[2])
        begin
            ctl3_reg    <= ctl2_reg;
            tday3_reg   <= base2_reg + {9'd0, prod2_reg[60:38]};
            tz_amt3_reg <= tz_amt;
            tz_neg3_reg <= tz2_reg[4];
        end
        // zone offset, clamp at zero when subtracting
        if (rdy[3])
        begin
            ctl4_reg <= ctl3_reg;
            if (!tz_neg3_reg)
            begin
                t4_reg <= tday3_reg + {16'd0, tz_amt3_reg};
            end
            else if (tday3_reg > {16'd0, tz_amt3_reg})
            begin
                t4_reg <= tday3_reg - {16'd0, tz_amt3_reg};
            end
            else
            begin
                t4_reg <= '0;
            end
        end
        // seconds to minutes, multiply
        if (rdy[4])
        begin
            ctl5_reg  <= ctl4_reg;
            t_lo5_reg <= t4_reg[5:0];
            prod5_reg <= t4_reg * sntp_pkg::RECIP_60;
        end
        // second of minute
        if (rdy[5])
        begin
            ctl6_reg  <= ctl5_reg;
            ss6_reg   <= t_lo5_reg - 6'(q60_a[5:0] * 6'd60);
            q60_6_reg <= q60_a;
        end
        // minutes to hours, multiply
        if (rdy[6])
        begin
            ctl7_reg    <= ctl6_reg;
            ss7_reg     <= ss6_reg;
            q60_lo7_reg <= q60_6_reg[5:0];
            prod7_reg   <= q60_6_reg * sntp_pkg::RECIP_60;
        end
        // minute of hour
        if (rdy[7])
        begin
            ctl8_reg <= ctl7_reg;
            ss8_reg  <= ss7_reg;
            mm8_reg  <= q60_lo7_reg - 6'(q3600[5:0] * 6'd60);
            h8_reg   <= q3600;
        end
        // hours / 24 as (hours / 8) / 3, multiply
        if (rdy[8])
        begin
            ctl9_reg  <= ctl8_reg;
            ss9_reg   <= ss8_reg;
            mm9_reg   <= mm8_reg;
            h_lo9_reg <= h8_reg[4:0];
            prod9_reg <= h8_reg[20:3] * sntp_pkg::RECIP_3;
        end
        // hour of day, blank until synced
        if (rdy[9])
        begin
            ctl10_reg <= ctl9_reg;
            if (ctl9_reg.synced)
            begin
                hh10_reg <= h_lo9_reg - 5'(q24[4:0] * 5'd24);
                mm10_reg <= mm9_reg;
                ss10_reg <= ss9_reg;
            end
            else
            begin
                hh10_reg <= '0;
                mm10_reg <= '0;
                ss10_reg <= '0;
            end
        end
    end

    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = {2'b00, ss10_reg, mm10_reg, hh10_reg, ctl10_reg.send_req,
                       ctl10_reg.lookup_req, ctl10_reg.synced, ctl10_reg.phase};

    // a valid reply always lands in synced with a fresh ms count
    a_reply_syncs: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && func == sntp_pkg::EV_REPLY && reply_long_enough
        && reply_seconds >= sntp_pkg::EPOCH_1970
        |=> phase_reg == sntp_pkg::PH_SYNCED && have_sync_reg
        && ms_since_sync_reg == 32'd0)
        else $error("valid reply did not sync");

    // start always restarts the lookup with a cleared phase timer
    a_start_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && func == sntp_pkg::EV_START
        |=> phase_reg == sntp_pkg::PH_LOOKUP && phase_elapsed_reg == 32'd0)
        else $error("start did not enter lookup pending");

    // once synced, the sync never goes away
    a_sync_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        have_sync_reg |=> have_sync_reg)
        else $error("sync flag dropped");

    // time fields are blank while unsynced
    a_blank_unsynced: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !ctl10_reg.synced |-> m_tdata[21:5] == 17'd0)
        else $error("time shown before sync");

    // lookup and send strobes never come from the same event
    a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(ctl10_reg.lookup_req && ctl10_reg.send_req))
        else $error("lookup and send requested together");

endmodule

/* bench/tb_sntp_sync_timekeeper.sv */
`timescale 1ns / 1ps

// one result as it travels on m_tdata, lowest bits last in this list
typedef struct packed {
    logic [1:0] pad;
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic       send_req;
    logic       lookup_req;
    logic       synced;
    logic [1:0] phase;
} tod_result_t;

// tracks the sync sequencer and clock, holds the results still due
class timekeeper_scoreboard;
    logic [31:0]   retry_ms;
    logic [31:0]   resync_ms;
    logic [31:0]   timeout_ms;
    logic [4:0]    tz_hours;

    sntp_pkg::phase_t cur_phase;
    logic [31:0]   phase_ms;
    logic [31:0]   base_secs;
    logic [31:0]   ms_synced;
    logic          have_sync;

    tod_result_t   due_results[$];
    int            errors;
    int            n_results;

    function new();
        retry_ms   = sntp_pkg::RETRY_MS_RST;
        resync_ms  = sntp_pkg::RESYNC_MS_RST;
        timeout_ms = sntp_pkg::TIMEOUT_MS_RST;
        tz_hours   = sntp_pkg::TZ_HOURS_RST;
        cur_phase  = sntp_pkg::PH_IDLE;
        phase_ms   = '0;
        base_secs  = '0;
        ms_synced  = '0;
        have_sync  = 1'b0;
        errors     = 0;
        n_results  = 0;
    endfunction

    function int pending();
        return due_results.size();
    endfunction

    function void set_reg(sntp_pkg::cfg_reg_t idx, logic [31:0] val);
        case (idx)
            sntp_pkg::REG_RETRY:   retry_ms   = val;
            sntp_pkg::REG_RESYNC:  resync_ms  = val;
            sntp_pkg::REG_TIMEOUT: timeout_ms = val;
            default:               tz_hours   = val[4:0];
        endcase
    endfunction

    function void enter_phase(sntp_pkg::phase_t p);
        cur_phase = p;
        phase_ms  = '0;
    endfunction

    // apply one accepted event and queue the result it must produce
    function void note_event(sntp_pkg::event_t kind, logic [15:0] el, logic ok,
                             logic long_ok, logic [31:0] secs);
        tod_result_t r;
        logic [31:0] t;
        logic [31:0] sub;
        r = '0;
        case (kind)
            sntp_pkg::EV_TICK:
            begin
                phase_ms = phase_ms + {16'd0, el};
                if (have_sync)
                    ms_synced = ms_synced + {16'd0, el};
                case (cur_phase)
                    sntp_pkg::PH_IDLE:
                    begin
                        if (phase_ms >= retry_ms)
                        begin
                            enter_phase(sntp_pkg::PH_LOOKUP);
                            r.lookup_req = 1'b1;
                        end
                    end
                    sntp_pkg::PH_LOOKUP:
                    begin
                        if (phase_ms >= retry_ms)
                            enter_phase(sntp_pkg::PH_IDLE);
                    end
                    sntp_pkg::PH_AWAIT:
                    begin
                        if (phase_ms >= timeout_ms)
                            enter_phase(sntp_pkg::PH_IDLE);
                    end
                    default:
                    begin
                        if (phase_ms >= resync_ms)
                        begin
                            enter_phase(sntp_pkg::PH_LOOKUP);
                            r.lookup_req = 1'b1;
                        end
                    end
                endcase
            end
            sntp_pkg::EV_START:
            begin
                enter_phase(sntp_pkg::PH_LOOKUP);
                r.lookup_req = 1'b1;
            end
            sntp_pkg::EV_LOOKUP:
            begin
                if (ok)
                begin
                    enter_phase(sntp_pkg::PH_AWAIT);
                    r.send_req = 1'b1;
                end
                else
                    enter_phase(sntp_pkg::PH_IDLE);
            end
            default:
            begin
                // short replies are dropped without any effect
                if (long_ok)
                begin
                    if (secs < sntp_pkg::EPOCH_1970)
                        enter_phase(sntp_pkg::PH_LOOKUP);
                    else
                    begin
                        base_secs = secs - sntp_pkg::EPOCH_1970;
                        ms_synced = '0;
                        have_sync = 1'b1;
                        enter_phase(sntp_pkg::PH_SYNCED);
                    end
                end
            end
        endcase

        // local time of day, negative zones clamp at zero
        if (have_sync)
        begin
            t = base_secs + ms_synced / 32'd1000;
            if (!tz_hours[4])
                t = t + {27'd0, tz_hours} * 32'd3600;
            else
            begin
                sub = (32'd32 - {27'd0, tz_hours}) * 32'd3600;
                t = (t > sub) ? t - sub : 32'd0;
            end
            r.seconds = 6'(t % 32'd60);
            r.minutes = 6'((t / 32'd60) % 32'd60);
            r.hours   = 5'((t / 32'd3600) % 32'd24);
        end
        r.phase  = cur_phase;
        r.synced = have_sync;
        due_results.push_back(r);
    endfunction

    task report(string msg);
        errors++;
        $display("tb: mismatch at result %0d: %s", n_results, msg);
    endtask

    task compare(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_result(logic [23:0] data);
        tod_result_t got;
        tod_result_t want;
        got = data;
        n_results++;
        if (due_results.size() == 0)
        begin
            report("result with no event pending");
            return;
        end
        want = due_results.pop_front();
        compare("phase", 32'(got.phase), 32'(want.phase));
        compare("synced_flag", 32'(got.synced), 32'(want.synced));
        compare("lookup_request", 32'(got.lookup_req), 32'(want.lookup_req));
        compare("send_request", 32'(got.send_req), 32'(want.send_req));
        compare("hours", 32'(got.hours), 32'(want.hours));
        compare("minutes", 32'(got.minutes), 32'(want.minutes));
        compare("seconds", 32'(got.seconds), 32'(want.seconds));
        compare("zero fill", 32'(got.pad), 32'(want.pad));
    endtask
endclass

module tb_sntp_sync_timekeeper;

    localparam int QUIET_LIMIT = 2000;
    localparam int ITEMS_PER_SETTING = 190;
    localparam int N_SETTINGS = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = sntp_pkg::EV_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = sntp_pkg::REG_RETRY;
    logic [31:0] cfg_data = '0;

    timekeeper_scoreboard sb = new();

    bit idle_on = 1'b1;
    int gap_pct = 20;
    int events_sent = 0;
    int stall_left = 0;
    int quiet = 0;

    sntp_sync_timekeeper i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // receiver stalls in random bursts while idling is on
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end
        else
            m_tready <= 1'b1;
    end

    // check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // stop the run if no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet == QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic logic [15:0] pick_ms();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(0, 2000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_secs();
        case ($urandom_range(0, 11))
            0:       return sntp_pkg::EPOCH_1970;
            1:       return sntp_pkg::EPOCH_1970 - 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'd0;
            4:       return $urandom_range(0, sntp_pkg::EPOCH_1970 - 32'd1);
            5, 6:    return sntp_pkg::EPOCH_1970 + $urandom_range(0, 200000);
            default: return $urandom_range(sntp_pkg::EPOCH_1970, 32'hFFFF_FFFF);
        endcase
    endfunction

    function automatic logic rand_bit();
        return $urandom_range(0, 1) != 0;
    endfunction

    // one event transfer, with an optional gap before it
    task automatic send_event(sntp_pkg::event_t kind, logic [15:0] el, logic ok,
                              logic long_ok, logic [31:0] secs);
        if (idle_on && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, secs, long_ok, ok, el};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_event(kind, el, ok, long_ok, secs);
        if (!(kind == sntp_pkg::EV_REPLY && !long_ok))
            events_sent++;
    endtask

    task automatic send_tick(logic [15:0] el);
        send_event(sntp_pkg::EV_TICK, el, rand_bit(), rand_bit(), $urandom());
    endtask

    task automatic send_reply(logic long_ok, logic [31:0] secs);
        send_event(sntp_pkg::EV_REPLY, pick_ms(), rand_bit(), long_ok, secs);
    endtask

    // wait until every result has come back and the pipeline is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // write all four registers in back-to-back transfers
    task automatic apply_setting(logic [31:0] retry, logic [31:0] resync,
                                 logic [31:0] timeout, logic [4:0] tz);
        logic [31:0] vals [4];
        vals[0] = retry;
        vals[1] = resync;
        vals[2] = timeout;
        vals[3] = {{27{tz[4]}}, tz};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= sntp_pkg::cfg_reg_t'(i);
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.set_reg(sntp_pkg::cfg_reg_t'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // mostly full sync handshakes with random content, plus noise
    task automatic run_random(int target);
        events_sent = 0;
        while (events_sent < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    send_event(sntp_pkg::EV_START, pick_ms(), rand_bit(), rand_bit(),
                               $urandom());
                    send_event(sntp_pkg::EV_LOOKUP, pick_ms(), $urandom_range(0, 9) != 0,
                               rand_bit(), $urandom());
                    send_reply($urandom_range(0, 9) != 0, pick_secs());
                    repeat ($urandom_range(0, 6)) send_tick(pick_ms());
                end
                6:
                    repeat ($urandom_range(5, 30)) send_tick(pick_ms());
                default:
                    send_event(sntp_pkg::event_t'($urandom_range(0, 3)), pick_ms(),
                               rand_bit(), $urandom_range(0, 4) != 0, pick_secs());
            endcase
        end
    endtask

    initial
    begin
        int tz_pick;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk through every phase at the reset settings
        send_tick(16'd0);
        send_tick(16'hFFFF);
        send_event(sntp_pkg::EV_LOOKUP, 16'hFFFF, 1'b0, 1'b1, 32'hFFFF_FFFF);
        send_event(sntp_pkg::EV_START, 16'd0, 1'b0, 1'b0, 32'd0);
        send_tick(16'hFFFF);
        send_event(sntp_pkg::EV_START, 16'hFFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_event(sntp_pkg::EV_LOOKUP, 16'd0, 1'b1, 1'b0, 32'd0);
        send_tick(16'hFFFF);
        send_event(sntp_pkg::EV_LOOKUP, 16'd0, 1'b1, 1'b0, 32'd0);
        send_reply(1'b0, 32'hFFFF_FFFF);
        send_reply(1'b1, sntp_pkg::EPOCH_1970 - 32'd1);
        send_reply(1'b1, sntp_pkg::EPOCH_1970);
        repeat (3) send_tick(16'hFFFF);
        send_reply(1'b1, 32'd0);
        send_reply(1'b1, 32'hFFFF_FFFF);
        send_tick(16'd999);
        send_event(sntp_pkg::EV_START, 16'd0, 1'b0, 1'b0, 32'd0);
        send_reply(1'b1, $urandom_range(sntp_pkg::EPOCH_1970, 32'hFFFF_FFFF));
        drain();

        // a run of register settings, extremes first, the last without idling
        for (int k = 0; k < N_SETTINGS; k++)
        begin
            tz_pick = $urandom_range(0, 26) - 12;
            case (k)
                0: apply_setting(32'd0, 32'd0, 32'd0, 5'b10100);
                1: apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd14);
                2: apply_setting($urandom_range(1, 100000), $urandom_range(1, 300000),
                                 $urandom_range(1, 30000), 5'b10000);
                3: apply_setting($urandom_range(1, 100000), $urandom_range(1, 300000),
                                 $urandom_range(1, 30000), 5'd15);
                N_SETTINGS - 1:
                    apply_setting(sntp_pkg::RETRY_MS_RST, sntp_pkg::RESYNC_MS_RST,
                                  sntp_pkg::TIMEOUT_MS_RST, sntp_pkg::TZ_HOURS_RST);
                default:
                    apply_setting($urandom_range(1, 100000), $urandom_range(1, 300000),
                                  $urandom_range(1, 30000), 5'(tz_pick));
            endcase
            idle_on = (k != N_SETTINGS - 1);
            gap_pct = $urandom_range(0, 40);
            run_random(ITEMS_PER_SETTING);
            drain();
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
design/sntp_pkg.sv
design/sntp_sync_timekeeper.sv
bench/tb_sntp_sync_timekeeper.sv
